// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the timer wheel modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define HTW_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// condition that must never be seen outside reset
`define HTW_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition");

`endif

// ===== rtl/core/htw_pkg.sv =====
// types and constants of the hierarchical timer wheel
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;
  localparam int ID_W = 6;
  localparam int TAG_W = 32;
  localparam int TICK_W = 32;
  localparam int LEVELS = 4;
  localparam int BKT_W = 2 * ID_W;

  localparam logic [ID_W-1:0] EMPTY_MARK = 6'd63;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_ADD_ACK    = 2'd0;
  localparam logic [1:0] KIND_CANCEL_ACK = 2'd1;
  localparam logic [1:0] KIND_EXPIRY     = 2'd2;
  localparam logic [1:0] KIND_TICK_DONE  = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLR,
    CMD_LATCH,
    CMD_ADD,
    CMD_CANCEL,
    CMD_PADDR,
    CMD_PRD,
    CMD_PWR_ADD,
    CMD_PWR_CASC,
    CMD_FSLOT,
    CMD_FHEAD,
    CMD_ADV,
    CMD_CSEL,
    CMD_CRD,
    CMD_CHEAD,
    CMD_WRD,
    CMD_FUSE,
    CMD_CUSE,
    CMD_DONE
  } htw_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic add_stop;
    logic walk_more;
    logic casc_go;
  } htw_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/htw_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/htw_ctrl.sv =====
// sequencer of the timer wheel
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module htw_ctrl
  import htw_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] op,
  input  wire htw_stat_t  stat,
  output htw_cmd_t        cmd,
  output logic            busy
);
  typedef enum logic [16:0] {
    S_CLR   = 17'h00001,
    S_IDLE  = 17'h00002,
    S_ADD   = 17'h00004,
    S_CAN   = 17'h00008,
    S_PADDR = 17'h00010,
    S_PRD   = 17'h00020,
    S_PWR   = 17'h00040,
    S_FSLOT = 17'h00080,
    S_FHEAD = 17'h00100,
    S_ADV   = 17'h00200,
    S_CSEL  = 17'h00400,
    S_CRD   = 17'h00800,
    S_CHEAD = 17'h01000,
    S_WCHK  = 17'h02000,
    S_WRD   = 17'h04000,
    S_WUSE  = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  typedef enum logic [1:0] {
    PH_ADD,
    PH_FIRE1,
    PH_CASC,
    PH_FIRE2
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      phase <= PH_ADD;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd = CMD_NOP;
    case (state)
      S_CLR: begin
        cmd = CMD_CLR;
        if (stat.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd = CMD_LATCH;
          case (op)
            OP_ADD: begin
              state_next = S_ADD;
              phase_next = PH_ADD;
            end
            OP_CANCEL: state_next = S_CAN;
            OP_TICK: begin
              state_next = S_FSLOT;
              phase_next = PH_FIRE1;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd = CMD_ADD;
        state_next = stat.add_stop ? S_IDLE : S_PADDR;
      end
      S_CAN: begin
        cmd = CMD_CANCEL;
        state_next = S_IDLE;
      end
      S_PADDR: begin
        cmd = CMD_PADDR;
        state_next = S_PRD;
      end
      S_PRD: begin
        cmd = CMD_PRD;
        state_next = S_PWR;
      end
      S_PWR: begin
        if (phase == PH_ADD) begin
          cmd = CMD_PWR_ADD;
          state_next = S_IDLE;
        end else begin
          cmd = CMD_PWR_CASC;
          state_next = S_WCHK;
        end
      end
      S_FSLOT: begin
        cmd = CMD_FSLOT;
        state_next = S_FHEAD;
      end
      S_FHEAD: begin
        cmd = CMD_FHEAD;
        state_next = S_WCHK;
      end
      S_ADV: begin
        cmd = CMD_ADV;
        state_next = S_CSEL;
      end
      S_CSEL: begin
        cmd = CMD_CSEL;
        if (stat.casc_go) begin
          state_next = S_CRD;
          phase_next = PH_CASC;
        end else begin
          state_next = S_FSLOT;
          phase_next = PH_FIRE2;
        end
      end
      S_CRD: begin
        cmd = CMD_CRD;
        state_next = S_CHEAD;
      end
      S_CHEAD: begin
        cmd = CMD_CHEAD;
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (stat.walk_more) begin
          state_next = S_WRD;
        end else begin
          case (phase)
            PH_FIRE1: state_next = S_ADV;
            PH_CASC: begin
              state_next = S_FSLOT;
              phase_next = PH_FIRE2;
            end
            PH_FIRE2: state_next = S_DONE;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_WRD: begin
        cmd = CMD_WRD;
        state_next = S_WUSE;
      end
      S_WUSE: begin
        if (phase == PH_CASC) begin
          cmd = CMD_CUSE;
          state_next = S_PADDR;
        end else begin
          cmd = CMD_FUSE;
          state_next = S_WCHK;
        end
      end
      S_DONE: begin
        cmd = CMD_DONE;
        state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
  end

  assign busy = (state != S_IDLE);

  `HTW_ASSERT(a_tick_starts_fire, clk, rst, (state == S_IDLE && start && op == OP_TICK) |=> (state == S_FSLOT && phase == PH_FIRE1))
  `HTW_ASSERT(a_add_phase_place, clk, rst, (state == S_PWR && phase == PH_ADD) |=> (state == S_IDLE))
  `HTW_ASSERT(a_cancel_returns, clk, rst, (state == S_CAN) |=> (state == S_IDLE))
endmodule
`default_nettype wire

// ===== rtl/core/htw_dp.sv =====
// datapath of the timer wheel: pool, bucket memories, time and results
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module htw_dp
  import htw_pkg::*;
#(
  parameter int NEAR_BITS  = 8,
  parameter int LEVEL_BITS = 6,
  parameter int POOL_SIZE  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire htw_cmd_t          cmd,
  output htw_stat_t              stat,
  input  wire logic [31:0]       delay,
  input  wire logic [TAG_W-1:0]  user_tag,
  input  wire logic [ID_W-1:0]   timer_id,
  output logic                   valid,
  output logic [1:0]             kind,
  output logic [ID_W-1:0]        handle,
  output logic [TAG_W-1:0]       tag_out,
  output logic [1:0]             status,
  output logic                   last
);
  localparam int EW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int GW = $clog2(POOL_SIZE + 1);
  localparam int NEAR_SLOTS = 1 << NEAR_BITS;
  localparam int LA_W = LEVEL_BITS + 2;
  localparam int LVL_TOTAL = 1 << LA_W;
  localparam int CLR_W = (NEAR_BITS > LA_W) ? NEAR_BITS : LA_W;
  localparam int CLR_TOTAL = 1 << CLR_W;

  logic [TICK_W-1:0]    cur_tick;
  logic [31:0]          delay_q;
  logic [TAG_W-1:0]     tag_q;
  logic [ID_W-1:0]      id_q;
  logic [ID_W-1:0]      e_idx;
  logic [ID_W-1:0]      nxt;
  logic [TICK_W-1:0]    x;
  logic [GW-1:0]        guard;
  logic                 p_near;
  logic [NEAR_BITS-1:0] p_naddr;
  logic [LA_W-1:0]      p_laddr;
  logic [LA_W-1:0]      cslot;
  logic [CLR_W-1:0]     clr_cnt;
  logic [POOL_SIZE-1:0] in_use;
  logic [POOL_SIZE-1:0] active;

  logic                 n_we, l_we, x_we, e_we;
  logic [NEAR_BITS-1:0] n_waddr, n_raddr;
  logic [LA_W-1:0]      l_waddr, l_raddr;
  logic [BKT_W-1:0]     n_wdata, l_wdata, n_rdata, l_rdata;
  logic [EW-1:0]        x_waddr;
  logic [ID_W-1:0]      x_wdata, x_rdata;
  logic [TICK_W+TAG_W-1:0] e_wdata, e_rdata;

  logic [ID_W-1:0]      b_head, b_tail, b_sel_head, b_sel_tail;
  logic                 b_link;
  logic [NEAR_BITS-1:0] cur_slot;
  logic                 free_found;
  logic [EW-1:0]        free_idx;
  logic                 immediate;
  logic [ID_W-1:0]      id_m1;
  logic                 id_ok;
  logic [EW-1:0]        e_lo;
  logic [TICK_W-1:0]    add_x;

  logic [TICK_W-1:0]    gap;
  logic [63:0]          gap64, x64, cur64;
  logic                 near_c;
  logic [1:0]           lvl_c;
  logic [LEVEL_BITS-1:0] slot_arr [LEVELS];
  logic                 casc_c;
  logic [LA_W-1:0]      cslot_c;

  assign cur_slot  = cur_tick[NEAR_BITS-1:0];
  assign e_lo      = e_idx[EW-1:0];
  assign immediate = (delay_q == 32'd0) || delay_q[31];
  assign add_x     = cur_tick + delay_q;
  assign id_m1     = id_q - 6'd1;
  assign id_ok     = (id_q != 6'd0) && (id_q <= ID_W'(POOL_SIZE)) && in_use[id_m1[EW-1:0]];

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx = EW'(i);
      end
    end
  end

  // placement of entry by its expiry
  always_comb begin
    gap    = x - cur_tick;
    gap64  = {32'd0, gap};
    x64    = {32'd0, x};
    near_c = gap64 < 64'(NEAR_SLOTS);
    lvl_c  = 2'd0;
    for (int l = 0; l < LEVELS - 1; l++) begin
      if (gap64 >= (64'd1 << (NEAR_BITS + (l + 1) * LEVEL_BITS))) begin
        lvl_c = 2'(l + 1);
      end
    end
    for (int l = 0; l < LEVELS; l++) begin
      slot_arr[l] = LEVEL_BITS'(x64 >> (NEAR_BITS + l * LEVEL_BITS));
    end
  end

  // cascade choice after the time advances
  always_comb begin
    cur64 = {32'd0, cur_tick};
    casc_c = 1'b0;
    cslot_c = '0;
    if (cur_tick == 32'd0) begin
      casc_c = 1'b1;
      cslot_c = {2'd3, {LEVEL_BITS{1'b0}}};
    end else begin
      for (int l = LEVELS - 1; l >= 0; l--) begin
        if (((cur64 & ((64'd1 << (NEAR_BITS + l * LEVEL_BITS)) - 64'd1)) == 64'd0) &&
            (LEVEL_BITS'(cur64 >> (NEAR_BITS + l * LEVEL_BITS)) != '0)) begin
          casc_c = 1'b1;
          cslot_c = {2'(l), LEVEL_BITS'(cur64 >> (NEAR_BITS + l * LEVEL_BITS))};
        end
      end
    end
  end

  assign b_head = p_near ? n_rdata[BKT_W-1:ID_W] : l_rdata[BKT_W-1:ID_W];
  assign b_tail = p_near ? n_rdata[ID_W-1:0] : l_rdata[ID_W-1:0];
  assign b_link = !((b_head == EMPTY_MARK) || (b_tail >= ID_W'(POOL_SIZE)));
  assign b_sel_head = b_link ? b_head : e_idx;
  assign b_sel_tail = e_idx;

  // memory ports
  always_comb begin
    n_we = 1'b0;
    n_waddr = p_naddr;
    n_wdata = {b_sel_head, b_sel_tail};
    l_we = 1'b0;
    l_waddr = p_laddr;
    l_wdata = {b_sel_head, b_sel_tail};
    x_we = 1'b0;
    x_waddr = e_lo;
    x_wdata = EMPTY_MARK;
    case (cmd)
      CMD_CLR: begin
        n_we = int'(clr_cnt) < NEAR_SLOTS;
        n_waddr = NEAR_BITS'(clr_cnt);
        n_wdata = {EMPTY_MARK, 6'd0};
        l_we = int'(clr_cnt) < LVL_TOTAL;
        l_waddr = LA_W'(clr_cnt);
        l_wdata = {EMPTY_MARK, 6'd0};
      end
      CMD_PADDR: x_we = 1'b1;
      CMD_PWR_ADD, CMD_PWR_CASC: begin
        n_we = p_near;
        l_we = !p_near;
        x_we = b_link;
        x_waddr = b_tail[EW-1:0];
        x_wdata = e_idx;
      end
      CMD_FHEAD: begin
        n_we = 1'b1;
        n_waddr = cur_slot;
        n_wdata = {EMPTY_MARK, n_rdata[ID_W-1:0]};
      end
      CMD_CHEAD: begin
        l_we = 1'b1;
        l_waddr = cslot;
        l_wdata = {EMPTY_MARK, l_rdata[ID_W-1:0]};
      end
      default: ;
    endcase
  end

  assign n_raddr = (cmd == CMD_FSLOT) ? cur_slot : p_naddr;
  assign l_raddr = (cmd == CMD_CRD) ? cslot : p_laddr;
  assign e_we    = (cmd == CMD_ADD) && !immediate && free_found;
  assign e_wdata = {add_x, tag_q};

  htw_ram #(.WIDTH(BKT_W), .DEPTH(NEAR_SLOTS)) u_near (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  htw_ram #(.WIDTH(BKT_W), .DEPTH(LVL_TOTAL)) u_level (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  htw_ram #(.WIDTH(ID_W), .DEPTH(POOL_SIZE)) u_next (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata),
    .raddr(e_lo), .rdata(x_rdata)
  );

  htw_ram #(.WIDTH(TICK_W + TAG_W), .DEPTH(POOL_SIZE)) u_entry (
    .clk(clk), .we(e_we), .waddr(free_idx), .wdata(e_wdata),
    .raddr(e_lo), .rdata(e_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_tick <= '0;
      in_use <= '0;
      active <= '0;
      clr_cnt <= '0;
      guard <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (cmd)
        CMD_CLR: clr_cnt <= clr_cnt + 1'b1;
        CMD_ADD: begin
          valid <= 1'b1;
          tag_out <= tag_q;
          status <= STAT_OK;
          last <= 1'b1;
          handle <= 6'd0;
          if (immediate) begin
            kind <= KIND_EXPIRY;
          end else if (!free_found) begin
            kind <= KIND_ADD_ACK;
            status <= STAT_FULL;
          end else begin
            valid <= 1'b0;
            e_idx <= ID_W'(free_idx);
            x <= add_x;
            in_use[free_idx] <= 1'b1;
            active[free_idx] <= 1'b1;
          end
        end
        CMD_CANCEL: begin
          valid <= 1'b1;
          kind <= KIND_CANCEL_ACK;
          handle <= id_q;
          tag_out <= '0;
          last <= 1'b1;
          status <= id_ok ? STAT_OK : STAT_NOT_FOUND;
          if (id_ok) begin
            active[id_m1[EW-1:0]] <= 1'b0;
          end
        end
        CMD_PADDR: begin
          p_near <= near_c;
          p_naddr <= x[NEAR_BITS-1:0];
          p_laddr <= {lvl_c, slot_arr[lvl_c]};
        end
        CMD_PWR_ADD: begin
          valid <= 1'b1;
          kind <= KIND_ADD_ACK;
          handle <= e_idx + 6'd1;
          tag_out <= tag_q;
          status <= STAT_OK;
          last <= 1'b1;
        end
        CMD_PWR_CASC: begin
          e_idx <= nxt;
          guard <= guard + 1'b1;
        end
        CMD_FHEAD: begin
          e_idx <= n_rdata[BKT_W-1:ID_W];
          guard <= '0;
        end
        CMD_ADV: cur_tick <= cur_tick + 32'd1;
        CMD_CSEL: cslot <= cslot_c;
        CMD_CHEAD: begin
          e_idx <= l_rdata[BKT_W-1:ID_W];
          guard <= '0;
        end
        CMD_FUSE: begin
          if (active[e_lo]) begin
            valid <= 1'b1;
            kind <= KIND_EXPIRY;
            handle <= e_idx + 6'd1;
            tag_out <= e_rdata[TAG_W-1:0];
            status <= STAT_OK;
            last <= 1'b0;
          end
          active[e_lo] <= 1'b0;
          in_use[e_lo] <= 1'b0;
          e_idx <= x_rdata;
          guard <= guard + 1'b1;
        end
        CMD_CUSE: begin
          x <= e_rdata[TICK_W+TAG_W-1:TAG_W];
          nxt <= x_rdata;
        end
        CMD_DONE: begin
          valid <= 1'b1;
          kind <= KIND_TICK_DONE;
          handle <= 6'd0;
          tag_out <= '0;
          status <= STAT_OK;
          last <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LATCH) begin
      delay_q <= delay;
      tag_q <= user_tag;
      id_q <= timer_id;
    end
  end

  assign stat.clr_done  = (clr_cnt == CLR_W'(CLR_TOTAL - 1));
  assign stat.add_stop  = immediate || !free_found;
  assign stat.walk_more = (e_idx < ID_W'(POOL_SIZE)) && (guard < GW'(POOL_SIZE));
  assign stat.casc_go   = casc_c;

  `HTW_NEVER(a_guard_range, clk, rst, guard > GW'(POOL_SIZE))
  `HTW_ASSERT(a_quiet_after_last, clk, rst, (valid && last) |=> !valid)
  `HTW_ASSERT(a_tick_done_last, clk, rst, (valid && kind == KIND_TICK_DONE) |-> last)
endmodule
`default_nettype wire

// ===== rtl/core/hierarchical_timer_wheel.sv =====
// top level of the hierarchical timer wheel
//
// Commands enter on start with op, delay, user_tag and timer_id; a command is
// taken at a rising edge where start is high and busy is low. op 0 adds a
// timer, op 1 cancels one by handle, op 2 advances time by one tick, op 3 is
// ignored. Results leave one at a time on kind, handle, tag_out, status and
// last, each marked by valid for exactly one cycle; last is set on the final
// result of a command. The receiver cannot stall the results.
// A cancel or an immediate add answers from its single execute state; a
// placed add answers after entry allocation, address calculation, bucket
// read and bucket write. A tick fires the current near slot, advances time,
// selects a cascade slot and, when one is due, reads it and moves its
// entries down, then fires the new near slot: the walk follows linked lists
// through one read port of the entry and link memories, one entry at a time.
// After reset the bucket head memories are swept clear, one word a cycle,
// while busy stays high.
`timescale 1ns / 1ps
`default_nettype none
module hierarchical_timer_wheel
  import htw_pkg::*;
#(
  parameter int NEAR_BITS  = 8,
  parameter int LEVEL_BITS = 6,
  parameter int POOL_SIZE  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        op,
  input  wire logic [31:0]       delay,
  input  wire logic [TAG_W-1:0]  user_tag,
  input  wire logic [ID_W-1:0]   timer_id,
  output logic                   valid,
  output logic [1:0]             kind,
  output logic [ID_W-1:0]        handle,
  output logic [TAG_W-1:0]       tag_out,
  output logic [1:0]             status,
  output logic                   last
);
  htw_cmd_t  cmd;
  htw_stat_t stat;

  htw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .op(op),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  htw_dp #(
    .NEAR_BITS(NEAR_BITS), .LEVEL_BITS(LEVEL_BITS), .POOL_SIZE(POOL_SIZE)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .delay(delay), .user_tag(user_tag), .timer_id(timer_id),
    .valid(valid), .kind(kind), .handle(handle), .tag_out(tag_out),
    .status(status), .last(last)
  );
endmodule
`default_nettype wire
